@@ rtl/core/turn_segment_detector_core_assert.svh @@
// Assertion macros for the turn segment detector core.
// Used by the core modules; expects clk and rst_n in the enclosing scope.
`ifndef TURN_SEGMENT_DETECTOR_CORE_ASSERT_SVH
`define TURN_SEGMENT_DETECTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSD_ASSERT(lbl, prop, msg)
`define TSD_ASSERT_IMP(lbl, ante, cons, msg)
`define TSD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/tsd_pkg.sv @@
// Shared types, constants and helpers of the turn segment detector core.
// No dependencies.
`timescale 1ns / 1ps

package tsd_pkg;

    localparam int STEER_W = 16;
    localparam int VEL_W   = 16;
    localparam int TS_W    = 32;
    localparam int DT_W    = 20;
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 36;
    localparam int ACC_W   = 24;
    localparam int THR_W   = 15;
    localparam int DUR_W   = 32;

    localparam logic [DT_W-1:0]   US_PER_S     = 20'd1000000;
    localparam logic [PROD_W-1:0] ACC_SAT_MAG  = 36'd8388608;
    localparam logic [ACC_W-1:0]  ACC_MAX      = 24'h7FFFFF;
    localparam logic [ACC_W-1:0]  ACC_MIN      = 24'h800000;

    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_START_THR = 2'd1;
    localparam logic [1:0] REG_END_THR   = 2'd2;
    localparam logic [1:0] REG_MIN_TURN  = 2'd3;

    localparam logic              RST_ENABLE    = 1'b1;
    localparam logic [THR_W-1:0]  RST_START_THR = 15'd983;
    localparam logic [THR_W-1:0]  RST_END_THR   = 15'd328;
    localparam logic [DUR_W-1:0]  RST_MIN_TURN  = 32'd1000000;

    typedef struct packed {
        logic              enable;
        logic [THR_W-1:0]  start_thr;
        logic [THR_W-1:0]  end_thr;
        logic [DUR_W-1:0]  min_turn;
    } cfg_t;

    typedef struct packed {
        logic [1:0]               phase;
        logic                     report;
        logic [DUR_W-1:0]         duration;
        logic signed [ACC_W-1:0]  peak;
    } res_t;

    function automatic logic [STEER_W:0] abs_steer(logic [STEER_W-1:0] v);
        logic [STEER_W:0] sx;
        sx = {v[STEER_W-1], v};
        return v[STEER_W-1] ? (~sx + 17'd1) : sx;
    endfunction

endpackage

@@ rtl/core/tsd_accel_div.sv @@
// Lateral acceleration unit: one multiply by 1e6, then a radix-2 restoring
// divider shared over 36 steps. Depends on tsd_pkg and the assertion header.
`timescale 1ns / 1ps
`include "turn_segment_detector_core_assert.svh"

module tsd_accel_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [tsd_pkg::DIFF_W-1:0] diff,
    input  logic [tsd_pkg::DT_W-1:0]          dt,
    input  logic                              ack,
    output logic                              done,
    output logic signed [tsd_pkg::ACC_W-1:0]  accel
);

    localparam int MUL_W = tsd_pkg::DIFF_W + tsd_pkg::DT_W;
    localparam logic [5:0] LAST_STEP = 6'(tsd_pkg::PROD_W - 1);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_SAT} state_t;

    state_t                            state_reg;
    logic                              done_reg;
    logic [tsd_pkg::DIFF_W-1:0]        mag_reg;
    logic                              neg_reg;
    logic                              zero_reg;
    logic [tsd_pkg::DT_W-1:0]          dt_reg;
    logic [tsd_pkg::PROD_W-1:0]        work_reg;
    logic [tsd_pkg::DT_W-1:0]          rem_reg;
    logic [5:0]                        count_reg;
    logic [tsd_pkg::ACC_W-1:0]         accel_reg;

    logic [MUL_W-1:0]                  prod_full;
    logic [tsd_pkg::DT_W:0]            rem_shift;
    logic [tsd_pkg::DT_W:0]            rem_sub;
    logic                              fits;
    logic [tsd_pkg::DT_W-1:0]          rem_next;
    logic [tsd_pkg::PROD_W-1:0]        work_next;
    logic [tsd_pkg::ACC_W-1:0]         mag_sat;
    logic [tsd_pkg::ACC_W-1:0]         accel_next;
    logic [tsd_pkg::DIFF_W-1:0]        diff_mag;

    assign diff_mag  = diff[tsd_pkg::DIFF_W-1] ? (~diff + 17'd1) : diff;
    assign prod_full = MUL_W'(mag_reg) * MUL_W'(tsd_pkg::US_PER_S);

    assign rem_shift = {rem_reg, work_reg[tsd_pkg::PROD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dt_reg};
    assign fits      = rem_shift >= {1'b0, dt_reg};
    assign rem_next  = fits ? rem_sub[tsd_pkg::DT_W-1:0] : rem_shift[tsd_pkg::DT_W-1:0];
    assign work_next = {work_reg[tsd_pkg::PROD_W-2:0], fits};

    always_comb
    begin
        mag_sat = (work_reg > tsd_pkg::ACC_SAT_MAG) ? tsd_pkg::ACC_MIN
                                                     : work_reg[tsd_pkg::ACC_W-1:0];
        if (zero_reg)
        begin
            accel_next = '0;
        end
        else if (neg_reg)
        begin
            accel_next = ~mag_sat + 24'd1;
        end
        else if (mag_sat == tsd_pkg::ACC_MIN)
        begin
            accel_next = tsd_pkg::ACC_MAX;
        end
        else
        begin
            accel_next = mag_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ack)
                    begin
                        done_reg <= 1'b0;
                    end
                    if (start)
                    begin
                        mag_reg   <= diff_mag;
                        neg_reg   <= diff[tsd_pkg::DIFF_W-1];
                        zero_reg  <= (dt == '0);
                        dt_reg    <= dt;
                        done_reg  <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    work_reg  <= prod_full[tsd_pkg::PROD_W-1:0];
                    rem_reg   <= '0;
                    count_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    work_reg  <= work_next;
                    rem_reg   <= rem_next;
                    count_reg <= count_reg + 6'd1;
                    if (count_reg == LAST_STEP)
                    begin
                        state_reg <= S_SAT;
                    end
                end
                S_SAT:
                begin
                    accel_reg <= accel_next;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign accel = accel_reg;

    `TSD_ASSERT_IMP(a_start_when_idle, start, (state_reg == S_IDLE) && !done_reg,
        "divider started while busy or holding a result")
    `TSD_ASSERT_NXT(a_div_length, (state_reg == S_DIV) && (count_reg == LAST_STEP),
        state_reg == S_SAT, "divider did not finish after its last step")
    `TSD_ASSERT_IMP(a_zero_interval, done_reg && zero_reg, accel_reg == '0,
        "zero interval gave a nonzero acceleration")

endmodule

@@ rtl/core/tsd_turn_fsm.sv @@
// Turn phase tracker with hysteresis, turn start, peak and report logic,
// plus the previous-sample registers. Depends on tsd_pkg and the assertion header.
`timescale 1ns / 1ps
`include "turn_segment_detector_core_assert.svh"

module tsd_turn_fsm
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               commit,
    input  tsd_pkg::cfg_t                      cfg,
    input  logic [tsd_pkg::STEER_W-1:0]        steering,
    input  logic [tsd_pkg::VEL_W-1:0]          velocity,
    input  logic [tsd_pkg::TS_W-1:0]           timestamp,
    input  logic signed [tsd_pkg::ACC_W-1:0]   accel,
    output logic [tsd_pkg::VEL_W-1:0]          prev_velocity,
    output tsd_pkg::res_t                      res
);

    localparam int CMP_W = (TIME_WIDTH > tsd_pkg::DUR_W) ? TIME_WIDTH : tsd_pkg::DUR_W;

    typedef enum logic [1:0] {PH_IDLE = 2'd0, PH_UNDER = 2'd1, PH_OVER = 2'd2} phase_t;

    phase_t                           phase_reg;
    logic [tsd_pkg::STEER_W-1:0]      prev_steer_reg;
    logic [tsd_pkg::VEL_W-1:0]        prev_vel_reg;
    logic [TIME_WIDTH-1:0]            prev_ts_reg;
    logic [TIME_WIDTH-1:0]            turn_start_reg;
    logic signed [tsd_pkg::ACC_W-1:0] peak_reg;

    phase_t                           phase_next;
    logic [TIME_WIDTH-1:0]            turn_start_next;
    logic signed [tsd_pkg::ACC_W-1:0] peak_next;
    logic [TIME_WIDTH-1:0]            now;
    logic [TIME_WIDTH-1:0]            span;
    logic [tsd_pkg::STEER_W:0]        a_mag;
    logic [tsd_pkg::STEER_W:0]        pa_mag;
    logic                             report;

    assign now    = TIME_WIDTH'(timestamp);
    assign span   = now - turn_start_reg;
    assign a_mag  = tsd_pkg::abs_steer(steering);
    assign pa_mag = tsd_pkg::abs_steer(prev_steer_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        turn_start_next = turn_start_reg;
        peak_next       = peak_reg;
        report          = 1'b0;
        if (cfg.enable)
        begin
            unique case (phase_reg)
                PH_UNDER:
                begin
                    if (a_mag >= 17'(cfg.start_thr))
                    begin
                        phase_next = PH_OVER;
                    end
                    else if (a_mag < pa_mag)
                    begin
                        phase_next      = PH_IDLE;
                        turn_start_next = '0;
                    end
                end
                PH_OVER:
                begin
                    if (a_mag < 17'(cfg.end_thr))
                    begin
                        phase_next = PH_UNDER;
                        report     = CMP_W'(span) >= CMP_W'(cfg.min_turn);
                        peak_next  = '0;
                    end
                end
                default:
                begin
                    if (a_mag >= pa_mag)
                    begin
                        phase_next      = PH_UNDER;
                        turn_start_next = prev_ts_reg;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
            if ((phase_next == PH_OVER) && (accel > peak_reg))
            begin
                peak_next = accel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            prev_steer_reg <= '0;
            prev_vel_reg   <= '0;
            prev_ts_reg    <= '0;
            turn_start_reg <= '0;
            peak_reg       <= '0;
        end
        else if (commit)
        begin
            phase_reg      <= phase_next;
            prev_steer_reg <= steering;
            prev_vel_reg   <= velocity;
            prev_ts_reg    <= now;
            turn_start_reg <= turn_start_next;
            peak_reg       <= peak_next;
        end
    end

    assign prev_velocity = prev_vel_reg;
    assign res.phase     = phase_next;
    assign res.report    = report;
    assign res.duration  = report ? tsd_pkg::DUR_W'(span) : '0;
    assign res.peak      = report ? peak_reg : '0;

    `TSD_ASSERT_IMP(a_report_source, commit && report,
        (phase_reg == PH_OVER) && cfg.enable, "report outside an above-threshold exit")
    `TSD_ASSERT_IMP(a_peak_only_over, commit && (phase_next != PH_OVER),
        peak_next == peak_reg || peak_next == '0, "peak moved outside above-threshold phase")

endmodule

@@ rtl/core/turn_segment_detector_core.sv @@
// Top level of the turn segment detector: stream ports, APB registers,
// output register. Depends on tsd_pkg, tsd_accel_div, tsd_turn_fsm.
`timescale 1ns / 1ps
`include "turn_segment_detector_core_assert.svh"

// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    s_tdata: one telemetry sample
// m_*       out        m_tvalid / m_tready    m_tdata, m_tuser: one result
// APB       in         psel/penable/pready    four 32-bit registers at 0x0..0xC
//
// From accept to result each sample passes a multiply state, then
// 36 steps of the shared restoring divider, a saturation state and the commit.
// s_tready is low from accept until the result enters the output register.
// A result waits in the output register while the next sample is taken; a
// stalled output holds the divider result and delays the commit.
// Reset clears phase, previous sample, turn start, peak and registers to defaults.

module turn_segment_detector_core
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] steering, [31:16] lat_velocity, [63:32] timestamp_us,
    // [83:64] interval_us, [87:84] zero
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [23:0] lat_accel, [25:24] turn_phase, [57:26] turn_duration_us,
    // [81:58] turn_peak_accel, [87:82] zero
    output logic [87:0] m_tdata,
    // [0] report_valid
    output logic [0:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tsd_pkg::cfg_t                     cfg_reg;
    logic                              busy_reg;
    logic                              m_tvalid_reg;
    logic [87:0]                       m_tdata_reg;
    logic [0:0]                        m_tuser_reg;
    logic [tsd_pkg::STEER_W-1:0]       steer_reg;
    logic [tsd_pkg::VEL_W-1:0]         vel_reg;
    logic [tsd_pkg::TS_W-1:0]          ts_reg;

    logic                              accept;
    logic                              commit;
    logic                              cfg_write;
    logic                              div_done;
    logic signed [tsd_pkg::DIFF_W-1:0] vel_diff;
    logic signed [tsd_pkg::ACC_W-1:0]  accel;
    logic [tsd_pkg::VEL_W-1:0]         prev_velocity;
    tsd_pkg::res_t                     res;

    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && !busy_reg;
    assign commit    = div_done && (!m_tvalid_reg || m_tready);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign vel_diff  = {s_tdata[31], s_tdata[31:16]} - {prev_velocity[15], prev_velocity};

    tsd_accel_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .diff  (vel_diff),
        .dt    (s_tdata[83:64]),
        .ack   (commit),
        .done  (div_done),
        .accel (accel)
    );

    tsd_turn_fsm #(.TIME_WIDTH(TIME_WIDTH)) u_fsm
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .commit        (commit),
        .cfg           (cfg_reg),
        .steering      (steer_reg),
        .velocity      (vel_reg),
        .timestamp     (ts_reg),
        .accel         (accel),
        .prev_velocity (prev_velocity),
        .res           (res)
    );

    always_comb
    begin
        unique case (paddr[3:2])
            tsd_pkg::REG_ENABLE:    prdata = {31'd0, cfg_reg.enable};
            tsd_pkg::REG_START_THR: prdata = {17'd0, cfg_reg.start_thr};
            tsd_pkg::REG_END_THR:   prdata = {17'd0, cfg_reg.end_thr};
            tsd_pkg::REG_MIN_TURN:  prdata = cfg_reg.min_turn;
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable    <= tsd_pkg::RST_ENABLE;
            cfg_reg.start_thr <= tsd_pkg::RST_START_THR;
            cfg_reg.end_thr   <= tsd_pkg::RST_END_THR;
            cfg_reg.min_turn  <= tsd_pkg::RST_MIN_TURN;
            busy_reg          <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (paddr[3:2])
                    tsd_pkg::REG_ENABLE:    cfg_reg.enable    <= pwdata[0];
                    tsd_pkg::REG_START_THR: cfg_reg.start_thr <= pwdata[14:0];
                    tsd_pkg::REG_END_THR:   cfg_reg.end_thr   <= pwdata[14:0];
                    tsd_pkg::REG_MIN_TURN:  cfg_reg.min_turn  <= pwdata;
                    default:                cfg_reg           <= cfg_reg;
                endcase
            end
            if (accept)
            begin
                busy_reg  <= 1'b1;
                steer_reg <= s_tdata[15:0];
                vel_reg   <= s_tdata[31:16];
                ts_reg    <= s_tdata[63:32];
            end
            else if (commit)
            begin
                busy_reg <= 1'b0;
            end
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {6'd0, res.peak, res.duration, res.phase, accel};
                m_tuser_reg  <= res.report;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `TSD_ASSERT_NXT(a_commit_shows, commit, m_tvalid_reg && !busy_reg,
        "committed result not presented or block still busy")
    `TSD_ASSERT_IMP(a_done_needs_busy, div_done, busy_reg,
        "divider result present with no sample in flight")

endmodule

@@ verif/turn_segment_detector_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for turn_segment_detector_core: streams telemetry samples,
// predicts every result with a local turn detector model and compares each output beat.
// Depends on tsd_pkg and the turn_segment_detector_core RTL.

module turn_segment_detector_core_tb;

    localparam int CLK_HALF      = 5;
    localparam int RST_CYCLES    = 9;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTED  = 10;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_CYCLES  = 500;

    typedef enum logic [1:0]
    {
        PH_IDLE  = 2'd0,
        PH_UNDER = 2'd1,
        PH_OVER  = 2'd2
    } turn_phase_t;

    typedef struct {
        logic [tsd_pkg::STEER_W-1:0] steering;
        logic [tsd_pkg::VEL_W-1:0]   lat_velocity;
        logic [tsd_pkg::TS_W-1:0]    timestamp;
        logic [tsd_pkg::DT_W-1:0]    interval;
    } sample_t;

    typedef struct {
        logic [tsd_pkg::ACC_W-1:0] lat_accel;
        logic [1:0]                phase;
        logic                      report;
        logic [tsd_pkg::DUR_W-1:0] duration;
        logic [tsd_pkg::ACC_W-1:0] peak;
    } turn_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    turn_segment_detector_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // model state and register copy
    logic                      cfg_enable;
    logic [tsd_pkg::THR_W-1:0] cfg_start_thr;
    logic [tsd_pkg::THR_W-1:0] cfg_end_thr;
    logic [tsd_pkg::DUR_W-1:0] cfg_min_turn;
    turn_phase_t               det_phase;
    int                        last_steer;
    int                        last_vel;
    logic [tsd_pkg::TS_W-1:0]  last_ts;
    logic [tsd_pkg::TS_W-1:0]  turn_start;
    int                        peak_accel;
    turn_result_t              expected_q[$];

    // stimulus state
    logic [tsd_pkg::TS_W-1:0]  gen_ts;
    int                        gen_vel;
    int                        send_idle_pct;
    int                        recv_idle_pct;
    int                        hold_req;
    int                        hold_left;
    int                        items_sent;
    int                        mismatches;
    int                        results_seen;
    int                        cycle_cnt;

    always #CLK_HALF clk = ~clk;

    function automatic int accel_of(int vel, int pvel, logic [tsd_pkg::DT_W-1:0] dt);
        longint diff;
        longint mag;
        longint q;
        if (dt == '0)
            return 0;
        diff = longint'(vel) - longint'(pvel);
        mag  = (diff < 0) ? -diff : diff;
        mag  = mag * longint'(tsd_pkg::US_PER_S);
        mag  = mag / longint'(dt);
        if (mag > 64'sd8388608)
            mag = 64'sd8388608;
        q = (diff < 0) ? -mag : mag;
        if (q > 64'sd8388607)
            q = 64'sd8388607;
        return int'(q);
    endfunction

    function automatic turn_result_t predict_turn(sample_t smp);
        turn_result_t             r;
        int                       steer;
        int                       vel;
        int                       acc;
        int                       mag;
        int                       last_mag;
        turn_phase_t              nxt;
        logic [tsd_pkg::TS_W-1:0] span;
        steer    = $signed(smp.steering);
        vel      = $signed(smp.lat_velocity);
        acc      = accel_of(vel, last_vel, smp.interval);
        mag      = (steer < 0) ? -steer : steer;
        last_mag = (last_steer < 0) ? -last_steer : last_steer;
        r.lat_accel = acc[tsd_pkg::ACC_W-1:0];
        r.report    = 1'b0;
        r.duration  = '0;
        r.peak      = '0;
        if (cfg_enable)
        begin
            nxt = det_phase;
            case (det_phase)
                PH_IDLE:
                begin
                    if (mag >= last_mag)
                        nxt = PH_UNDER;
                end
                PH_UNDER:
                begin
                    if (mag >= int'(cfg_start_thr))
                        nxt = PH_OVER;
                    else if (mag < last_mag)
                        nxt = PH_IDLE;
                end
                default:
                begin
                    if (mag < int'(cfg_end_thr))
                        nxt = PH_UNDER;
                end
            endcase
            if (nxt != det_phase)
            begin
                if (nxt == PH_UNDER && det_phase == PH_IDLE)
                    turn_start = last_ts;
                else if (nxt == PH_UNDER && det_phase == PH_OVER)
                begin
                    span = smp.timestamp - turn_start;
                    if (span >= cfg_min_turn)
                    begin
                        r.report   = 1'b1;
                        r.duration = span;
                        r.peak     = peak_accel[tsd_pkg::ACC_W-1:0];
                    end
                    peak_accel = 0;
                end
                else if (nxt == PH_IDLE)
                    turn_start = '0;
            end
            det_phase = nxt;
            if (det_phase == PH_OVER && acc > peak_accel)
                peak_accel = acc;
        end
        r.phase    = det_phase;
        last_steer = steer;
        last_vel   = vel;
        last_ts    = smp.timestamp;
        return r;
    endfunction

    function automatic sample_t mk_sample(int steer, int vel, logic [tsd_pkg::TS_W-1:0] ts,
                                          logic [tsd_pkg::DT_W-1:0] dt);
        sample_t smp;
        smp.steering     = steer[tsd_pkg::STEER_W-1:0];
        smp.lat_velocity = vel[tsd_pkg::VEL_W-1:0];
        smp.timestamp    = ts;
        smp.interval     = dt;
        return smp;
    endfunction

    function automatic sample_t telemetry(int steer);
        int          dv;
        int unsigned dt;
        case ($urandom_range(19))
            0:       dt = 0;
            1:       dt = (1 << tsd_pkg::DT_W) - 1;
            2:       dt = $urandom_range(1, 50);
            default: dt = $urandom_range(2000, 250000);
        endcase
        if ($urandom_range(15) == 0)
            dv = int'($urandom_range(65535)) - 32768;
        else
            dv = gen_vel + int'($urandom_range(800)) - 400;
        if (dv > 32767)
            dv = 32767;
        if (dv < -32768)
            dv = -32768;
        gen_vel = dv;
        gen_ts  = gen_ts + dt;
        return mk_sample(steer, dv, gen_ts, dt[tsd_pkg::DT_W-1:0]);
    endfunction

    function automatic sample_t noise_sample();
        sample_t smp;
        smp.steering     = tsd_pkg::STEER_W'($urandom);
        smp.lat_velocity = tsd_pkg::VEL_W'($urandom);
        smp.timestamp    = tsd_pkg::TS_W'($urandom);
        smp.interval     = tsd_pkg::DT_W'($urandom);
        return smp;
    endfunction

    task automatic send_sample(sample_t smp);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, smp.interval, smp.timestamp, smp.lat_velocity, smp.steering};
        do @(posedge clk); while (!s_tready);
        expected_q.push_back(predict_turn(smp));
        items_sent++;
    endtask

    task automatic drain_stream();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tsd_pkg::REG_ENABLE:    cfg_enable    = value[0];
            tsd_pkg::REG_START_THR: cfg_start_thr = value[tsd_pkg::THR_W-1:0];
            tsd_pkg::REG_END_THR:   cfg_end_thr   = value[tsd_pkg::THR_W-1:0];
            tsd_pkg::REG_MIN_TURN:  cfg_min_turn  = value;
            default:                ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(logic en, int unsigned start_thr, int unsigned end_thr,
                             logic [31:0] min_turn);
        drain_stream();
        write_reg(tsd_pkg::REG_ENABLE, {31'b0, en});
        write_reg(tsd_pkg::REG_START_THR, start_thr & 32'h7FFF);
        write_reg(tsd_pkg::REG_END_THR, end_thr & 32'h7FFF);
        write_reg(tsd_pkg::REG_MIN_TURN, min_turn);
    endtask

    task automatic configure_random();
        int unsigned start_thr;
        start_thr = $urandom_range(200, 12000);
        configure(1'b1, start_thr, $urandom_range(0, start_thr), $urandom_range(0, 3000000));
    endtask

    // one steering excursion: ramp up, hold near the top, ramp down
    task automatic send_turn();
        int top;
        int sgn;
        int rise;
        int hold;
        int fall;
        sgn = $urandom_range(1) ? -1 : 1;
        case ($urandom_range(3))
            0, 1:    top = $urandom_range(cfg_start_thr, 32767);
            2:       top = $urandom_range(cfg_end_thr, cfg_start_thr);
            default: top = $urandom_range(32767);
        endcase
        if (sgn < 0 && $urandom_range(7) == 0)
            top = 32768;
        rise = $urandom_range(1, 5);
        hold = $urandom_range(0, 10);
        fall = $urandom_range(1, 5);
        for (int i = 1; i <= rise; i++)
            send_sample(telemetry(sgn * (top * i / rise)));
        for (int i = 0; i < hold; i++)
            send_sample(telemetry(sgn * (top - int'($urandom_range(top / 8)))));
        for (int i = fall - 1; i >= 0; i--)
            send_sample(telemetry(sgn * (top * i / fall)));
    endtask

    task automatic run_random(int n_items);
        int goal;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            if ($urandom_range(9) < 8)
                send_turn();
            else
                repeat ($urandom_range(1, 4)) send_sample(noise_sample());
        end
    endtask

    task automatic test_directed_edges();
        send_sample(mk_sample(0, 0, 32'd0, 20'd0));
        send_sample(mk_sample(-32768, 32767, 32'd1000, 20'd1));
        send_sample(mk_sample(32767, -32768, 32'd2000, 20'd1));
        send_sample(mk_sample(100, -32765, 32'd2000000, 20'hFFFFF));
        send_sample(mk_sample(50, -32768, 32'd2100000, 20'hFFFFF));
        send_sample(mk_sample(60, -32768, 32'd2200000, 20'd100000));
        send_sample(mk_sample(983, 0, 32'd2300000, 20'd100000));
        send_sample(mk_sample(-328, 200, 32'd2400000, 20'd100000));
        send_sample(mk_sample(327, 100, 32'd2500000, 20'd100000));
        send_sample(mk_sample(-200, 100, 32'd2600000, 20'd100000));
        send_sample(mk_sample(0, 0, 32'hFFF0_0000, 20'd3));
        send_sample(mk_sample(10, 5, 32'hFFF8_0000, 20'd7));
        send_sample(mk_sample(5000, 32767, 32'h0000_1000, 20'd9));
        send_sample(mk_sample(-20, -32768, 32'h0010_0000, 20'd11));
        send_sample(mk_sample(0, 0, 32'h0020_0000, 20'd50000));
        send_sample(mk_sample(1, 0, 32'h0030_0000, 20'd50000));
        send_sample(mk_sample(2000, 0, 32'h0038_0000, 20'd50000));
        send_sample(mk_sample(0, 0, 32'h0020_0000 + 32'd1000000, 20'd50000));
        send_sample(mk_sample(3000, 0, 32'h0020_0000 + 32'd1000001, 20'd50000));
        send_sample(mk_sample(0, 0, 32'h0020_0000 + 32'd1999999, 20'd50000));
        send_sample(mk_sample(32767, 32767, 32'hFFFF_FFFF, 20'hFFFFF));
        send_sample(mk_sample(-32768, -32768, 32'hFFFF_FFFF, 20'hFFFFF));
        gen_ts = 32'hFFFF_FFFF;
        drain_stream();
    endtask

    task automatic test_register_extremes();
        configure(1'b1, 0, 0, 32'd0);
        run_random(60);
        configure(1'b1, 32767, 32767, 32'hFFFF_FFFF);
        run_random(60);
        configure(1'b1, 32767, 0, 32'd0);
        run_random(60);
        configure(1'b1, 0, 32767, 32'd500000);
        run_random(60);
        configure_random();
        run_random(60);
        configure_random();
        run_random(60);
        configure(1'b1, 32'(tsd_pkg::RST_START_THR), 32'(tsd_pkg::RST_END_THR),
                  tsd_pkg::RST_MIN_TURN);
        run_random(60);
        drain_stream();
    endtask

    task automatic test_disabled_hold();
        configure(1'b1, 983, 328, 32'd200000);
        send_sample(telemetry(0));
        send_sample(telemetry(400));
        send_sample(telemetry(-6000));
        configure(1'b0, 983, 328, 32'd200000);
        run_random(40);
        configure(1'b1, 983, 328, 32'd200000);
        run_random(40);
        drain_stream();
    endtask

    task automatic test_idle_schedules();
        configure_random();
        run_random(300);
        drain_stream();
        send_idle_pct = 49;
        recv_idle_pct = 16;
        configure_random();
        run_random(300);
        drain_stream();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure_random();
        run_random(300);
        drain_stream();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = STALL_CYCLES;
        for (int i = 0; i < 16; i++)
            send_sample(telemetry(i * 900 - 4000));
        drain_stream();
    endtask

    always @(posedge clk)
    begin : rx_check
        turn_result_t want;
        turn_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.lat_accel = m_tdata[23:0];
            got.phase     = m_tdata[25:24];
            got.duration  = m_tdata[57:26];
            got.peak      = m_tdata[81:58];
            got.report    = m_tuser[0];
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("result %0d arrived with nothing expected", results_seen);
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.lat_accel !== got.lat_accel || want.phase !== got.phase
                    || want.report !== got.report || want.duration !== got.duration
                    || want.peak !== got.peak)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display("result %0d: exp accel=%0d phase=%0d rep=%0b dur=%0d peak=%0d",
                                 results_seen, $signed(want.lat_accel), want.phase,
                                 want.report, want.duration, $signed(want.peak),
                                 " | got accel=%0d phase=%0d rep=%0b dur=%0d peak=%0d",
                                 $signed(got.lat_accel), got.phase, got.report,
                                 got.duration, $signed(got.peak));
                end
            end
        end
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("turn_segment_detector_core verification failed");
            $finish;
        end
    end

    initial
    begin
        cfg_enable    = tsd_pkg::RST_ENABLE;
        cfg_start_thr = tsd_pkg::RST_START_THR;
        cfg_end_thr   = tsd_pkg::RST_END_THR;
        cfg_min_turn  = tsd_pkg::RST_MIN_TURN;
        det_phase     = PH_IDLE;
        last_steer    = 0;
        last_vel      = 0;
        last_ts       = '0;
        turn_start    = '0;
        peak_accel    = 0;
        gen_ts        = '0;
        gen_vel       = 0;
        send_idle_pct = 16;
        recv_idle_pct = 49;
        hold_req      = 0;
        hold_left     = 0;
        items_sent    = 0;
        mismatches    = 0;
        results_seen  = 0;
        cycle_cnt     = 0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_register_extremes();
        test_disabled_hold();
        test_idle_schedules();
        test_output_backpressure();

        drain_stream();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("turn_segment_detector_core verification clean");
        else
            $display("turn_segment_detector_core verification failed");
        $finish;
    end

endmodule
